@@ src/cmtc_pkg.sv @@
// shared types, codes and constants of the cover motor travel controller
`default_nettype none

package cmtc_pkg;

  // default width of the seconds counter
  localparam int unsigned TimeWidthDef = 16;

  // fixed field widths
  localparam int unsigned SecW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  // cover mode codes
  localparam logic [1:0] MODE_OPEN    = 2'd0;
  localparam logic [1:0] MODE_OPENING = 2'd1;
  localparam logic [1:0] MODE_CLOSING = 2'd2;
  localparam logic [1:0] MODE_CLOSED  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MIN_OPEN     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_OPEN     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DEFAULT_OPEN = 2'd2;

  // configuration reset values
  localparam logic [SecW-1:0] MIN_OPEN_RST     = 16'd10;
  localparam logic [SecW-1:0] MAX_OPEN_RST     = 16'd60;
  localparam logic [SecW-1:0] DEFAULT_OPEN_RST = 16'd30;

  // drive duty while moving
  localparam logic [7:0] FULL_POWER = 8'd220;

  // configuration register set
  typedef struct packed {
    logic [SecW-1:0] min_open;
    logic [SecW-1:0] max_open;
    logic [SecW-1:0] default_open;
  } cfg_regs_t;

  // one result item
  typedef struct packed {
    logic [1:0]      cover_state;
    logic            motor_on;
    logic            motor_toward_close;
    logic [7:0]      motor_power;
    logic            is_open;
    logic            is_closed;
    logic [SecW-1:0] learned_seconds;
  } result_t;

endpackage

`default_nettype wire

@@ src/cmtc_if.sv @@
// request, result and configuration channel interfaces
`default_nettype none

interface cmtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       tilt_closed;

  modport source (output valid, output action, output tilt_closed, input ready);
  modport sink (input valid, input action, input tilt_closed, output ready);
endinterface

interface cmtc_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cover_state;
  logic                      motor_on;
  logic                      motor_toward_close;
  logic [7:0]                motor_power;
  logic                      is_open;
  logic                      is_closed;
  logic [cmtc_pkg::SecW-1:0] learned_seconds;

  modport source (output valid, output cover_state, output motor_on,
                  output motor_toward_close, output motor_power, output is_open,
                  output is_closed, output learned_seconds, input ready);
  modport sink (input valid, input cover_state, input motor_on,
                input motor_toward_close, input motor_power, input is_open,
                input is_closed, input learned_seconds, output ready);
endinterface

interface cmtc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cmtc_pkg::CfgIdxW-1:0] index;
  logic [cmtc_pkg::SecW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/cover_motor_travel_controller_top.sv @@
// top level of the cover motor travel controller
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+------------------------------------------
//  in_req_i  | in  | valid/ready  | action, tilt_closed
//  res_o     | out | valid/ready  | cover_state, motor_on, motor_toward_close,
//            |     |              | motor_power, is_open, is_closed,
//            |     |              | learned_seconds
//  cfg_i     | in  | valid/ready  | index, data (always ready)
//
//  one request per cycle unless the result stalls; its result is registered and shows in the cycle after acceptance
//  the result register sets the rate: a request is taken whenever the result
//  register is empty or is being drained in the same cycle
//  a stalled result holds and blocks new requests until taken
//  reset returns the cover to open, clears the counter and the learned time,
//  and loads the configuration defaults
`default_nettype none

module cover_motor_travel_controller_top #(
  parameter int unsigned TIME_WIDTH = cmtc_pkg::TimeWidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cmtc_in_if.sink   in_req_i,
  cmtc_out_if.source res_o,
  cmtc_cfg_if.sink  cfg_i
);

  cmtc_pkg::cfg_regs_t cfg_q;
  cmtc_pkg::result_t   res_d, res_q;
  logic                out_vld_q;
  logic                in_ready, in_fire;

  // request flow: take a new request while the result slot frees up
  assign in_ready       = !out_vld_q || res_o.ready;
  assign in_fire        = in_req_i.valid && in_ready;
  assign in_req_i.ready = in_ready;
  assign cfg_i.ready    = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_open     <= cmtc_pkg::MIN_OPEN_RST;
      cfg_q.max_open     <= cmtc_pkg::MAX_OPEN_RST;
      cfg_q.default_open <= cmtc_pkg::DEFAULT_OPEN_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        cmtc_pkg::REG_MIN_OPEN:     cfg_q.min_open     <= cfg_i.data;
        cmtc_pkg::REG_MAX_OPEN:     cfg_q.max_open     <= cfg_i.data;
        cmtc_pkg::REG_DEFAULT_OPEN: cfg_q.default_open <= cfg_i.data;
        default: ;
      endcase
    end
  end

  cmtc_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_fire),
    .action_i     (in_req_i.action),
    .tilt_closed_i(in_req_i.tilt_closed),
    .cfg_i        (cfg_q),
    .res_o        (res_d)
  );

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_ready) begin
      out_vld_q <= in_req_i.valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid              = out_vld_q;
  assign res_o.cover_state        = res_q.cover_state;
  assign res_o.motor_on           = res_q.motor_on;
  assign res_o.motor_toward_close = res_q.motor_toward_close;
  assign res_o.motor_power        = res_q.motor_power;
  assign res_o.is_open            = res_q.is_open;
  assign res_o.is_closed          = res_q.is_closed;
  assign res_o.learned_seconds    = res_q.learned_seconds;

endmodule

`default_nettype wire

@@ src/cmtc_core.sv @@
// cover mode state, seconds counter, travel learning and result computation
`default_nettype none

module cmtc_core #(
  parameter int unsigned TIME_WIDTH = cmtc_pkg::TimeWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [1:0]          action_i,
  input  wire logic                tilt_closed_i,
  input  wire cmtc_pkg::cfg_regs_t cfg_i,
  output cmtc_pkg::result_t        res_o
);

  // compare width: counter or travel time, plus room for times eleven
  localparam int unsigned BaseW = (TIME_WIDTH > cmtc_pkg::SecW) ? TIME_WIDTH : cmtc_pkg::SecW;
  localparam int unsigned CmpW  = BaseW + 5;

  logic [1:0]                mode_q, mode_d;
  logic [TIME_WIDTH-1:0]     elapsed_q, elapsed_d;
  logic [cmtc_pkg::SecW-1:0] learned_q, learned_d;
  logic                      learned_vld_q, learned_vld_d;

  logic [TIME_WIDTH-1:0]     elapsed_inc;
  logic [CmpW-1:0]           e_ext, e_plus1, e_times11;
  logic [CmpW-1:0]           travel_ext, travel_times10;
  logic [CmpW-1:0]           max_ext, min_ext;
  logic [cmtc_pkg::SecW-1:0] travel_cur;
  logic                      moving, below_max, past_min, sensor_open;
  logic                      q_open, q_closed, moving_d;

  // saturating tick count and the opening window
  always_comb begin
    elapsed_inc = (elapsed_q == {TIME_WIDTH{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
    e_ext       = CmpW'(elapsed_inc);
    max_ext     = CmpW'(cfg_i.max_open);
    min_ext     = CmpW'(cfg_i.min_open);
    below_max   = e_ext < max_ext;
    past_min    = e_ext >= min_ext;
    sensor_open = ~tilt_closed_i;
  end

  // closing end: e >= floor(10 * t / 11) holds exactly when 11 * (e + 1) > 10 * t
  always_comb begin
    travel_cur     = learned_vld_q ? learned_q : cfg_i.default_open;
    travel_ext     = CmpW'(travel_cur);
    travel_times10 = (travel_ext << 3) + (travel_ext << 1);
    e_plus1        = e_ext + 1'b1;
    e_times11      = (e_plus1 << 3) + (e_plus1 << 1) + e_plus1;
  end

  assign moving = (mode_q == cmtc_pkg::MODE_OPENING) || (mode_q == cmtc_pkg::MODE_CLOSING);

  // next state for one request
  always_comb begin
    mode_d        = mode_q;
    elapsed_d     = elapsed_q;
    learned_d     = learned_q;
    learned_vld_d = learned_vld_q;
    q_open        = 1'b0;
    q_closed      = 1'b0;
    case (action_i)
      cmtc_pkg::ACT_TICK: begin
        if (moving) begin
          elapsed_d = elapsed_inc;
          if (mode_q == cmtc_pkg::MODE_OPENING) begin
            if (!below_max || (past_min && sensor_open)) begin
              if (below_max && past_min && sensor_open) begin
                learned_d     = cmtc_pkg::SecW'(e_ext);
                learned_vld_d = 1'b1;
              end
              mode_d = cmtc_pkg::MODE_OPEN;
            end
          end else if (e_times11 > travel_times10) begin
            mode_d = cmtc_pkg::MODE_CLOSED;
          end
        end
      end
      cmtc_pkg::ACT_OPEN: begin
        elapsed_d = '0;
        mode_d    = cmtc_pkg::MODE_OPENING;
      end
      cmtc_pkg::ACT_CLOSE: begin
        elapsed_d = '0;
        mode_d    = cmtc_pkg::MODE_CLOSING;
      end
      default: begin
        // status query: sensor disagreement corrects the mode
        if (mode_q == cmtc_pkg::MODE_OPEN) begin
          if (tilt_closed_i) mode_d = cmtc_pkg::MODE_CLOSED;
          else               q_open = 1'b1;
        end else if (mode_q == cmtc_pkg::MODE_CLOSED) begin
          if (!tilt_closed_i) mode_d = cmtc_pkg::MODE_OPEN;
          else                q_closed = 1'b1;
        end
      end
    endcase
  end

  // result from the state after this request
  always_comb begin
    moving_d                 = (mode_d == cmtc_pkg::MODE_OPENING) ||
                               (mode_d == cmtc_pkg::MODE_CLOSING);
    res_o.cover_state        = mode_d;
    res_o.motor_on           = moving_d;
    res_o.motor_toward_close = (mode_d == cmtc_pkg::MODE_CLOSING);
    res_o.motor_power        = moving_d ? cmtc_pkg::FULL_POWER : 8'd0;
    res_o.is_open            = q_open;
    res_o.is_closed          = q_closed;
    res_o.learned_seconds    = learned_vld_d ? learned_d : cfg_i.default_open;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= cmtc_pkg::MODE_OPEN;
      elapsed_q     <= '0;
      learned_q     <= '0;
      learned_vld_q <= 1'b0;
    end else if (step_i) begin
      mode_q        <= mode_d;
      elapsed_q     <= elapsed_d;
      learned_q     <= learned_d;
      learned_vld_q <= learned_vld_d;
    end
  end

endmodule

`default_nettype wire

@@ src/cmtc_checker.sv @@
// port-level checks of the controller and their attachment to the top level
`default_nettype none

module cmtc_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [1:0]                cover_state,
  input wire logic                      motor_on,
  input wire logic                      motor_toward_close,
  input wire logic [7:0]                motor_power,
  input wire logic                      is_open,
  input wire logic                      is_closed,
  input wire logic [cmtc_pkg::SecW-1:0] learned_seconds
);

  // motor runs exactly in the moving modes
  a_motor_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (motor_on == ((cover_state == cmtc_pkg::MODE_OPENING) ||
                                (cover_state == cmtc_pkg::MODE_CLOSING))))
    else $error("motor enable disagrees with cover state");

  // duty follows the motor enable
  a_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (motor_power == (motor_on ? cmtc_pkg::FULL_POWER : 8'd0)))
    else $error("motor power disagrees with motor enable");

  // close direction only while closing
  a_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (motor_toward_close == (cover_state == cmtc_pkg::MODE_CLOSING)))
    else $error("drive direction disagrees with cover state");

  // a confirmed query answer matches the resting mode
  a_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (!(is_open && is_closed) &&
                   (!is_open || cover_state == cmtc_pkg::MODE_OPEN) &&
                   (!is_closed || cover_state == cmtc_pkg::MODE_CLOSED)))
    else $error("query answer disagrees with cover state");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(cover_state) &&
                                   $stable(learned_seconds)))
    else $error("stalled result changed");

endmodule

bind cover_motor_travel_controller_top cmtc_checker u_cmtc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid         (res_o.valid),
  .out_ready         (res_o.ready),
  .cover_state       (res_o.cover_state),
  .motor_on          (res_o.motor_on),
  .motor_toward_close(res_o.motor_toward_close),
  .motor_power       (res_o.motor_power),
  .is_open           (res_o.is_open),
  .is_closed         (res_o.is_closed),
  .learned_seconds   (res_o.learned_seconds)
);

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking testbench for the cover motor travel controller top level
`timescale 1ns / 100ps

module testbench;
  import cmtc_pkg::*;

  localparam int unsigned TimeW = TimeWidthDef;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned PhaseRequests = 270;

  // one request as queued for the driver, with an optional fixed expectation
  typedef struct packed {
    logic [1:0] action;
    logic       tilt_closed;
    logic       fixed;
    result_t    want;
  } cover_req_t;

  logic clk_i;
  logic rst_ni;

  cmtc_in_if  req_if ();
  cmtc_out_if res_if ();
  cmtc_cfg_if cfg_if ();

  cover_motor_travel_controller_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (req_if),
    .res_o    (res_if),
    .cfg_i    (cfg_if)
  );

  // requests waiting to be offered and results waiting to arrive
  cover_req_t  request_backlog[$];
  result_t     awaited_results[$];
  int unsigned queued_total;
  int unsigned mismatch_count;
  bit          long_stall_req;

  // predicted controller state and register shadow
  logic [1:0]       cover_mode;
  logic [TimeW-1:0] secs_elapsed;
  logic [SecW-1:0]  learned_time;
  logic             learned_valid;
  cfg_regs_t        shadow_cfg;

  initial begin
    queued_total   = 0;
    mismatch_count = 0;
    long_stall_req = 1'b0;
    cover_mode     = MODE_OPEN;
    secs_elapsed   = '0;
    learned_time   = '0;
    learned_valid  = 1'b0;
    shadow_cfg     = '{min_open: MIN_OPEN_RST, max_open: MAX_OPEN_RST,
                       default_open: DEFAULT_OPEN_RST};
  end

  // clock and reset
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // advance the predicted state by one request and return its result
  function automatic result_t next_cover_result(logic [1:0] action, logic tilt_closed);
    result_t     r;
    logic        q_open;
    logic        q_closed;
    logic        below_max;
    logic        past_min;
    int unsigned travel;
    int unsigned close_target;
    q_open   = 1'b0;
    q_closed = 1'b0;
    case (action)
      ACT_TICK: begin
        if (cover_mode == MODE_OPENING || cover_mode == MODE_CLOSING) begin
          if (secs_elapsed != '1) secs_elapsed = secs_elapsed + 1'b1;
          if (cover_mode == MODE_OPENING) begin
            below_max = secs_elapsed < shadow_cfg.max_open;
            past_min  = secs_elapsed >= shadow_cfg.min_open;
            if (!below_max || (past_min && !tilt_closed)) begin
              // clean stop inside the window learns the travel time
              if (below_max && past_min && !tilt_closed) begin
                learned_time  = secs_elapsed[SecW-1:0];
                learned_valid = 1'b1;
              end
              cover_mode = MODE_OPEN;
            end
          end else begin
            travel       = learned_valid ? 32'(learned_time) : 32'(shadow_cfg.default_open);
            close_target = (travel * 100) / 110;
            if (secs_elapsed >= close_target) cover_mode = MODE_CLOSED;
          end
        end
      end
      ACT_OPEN: begin
        secs_elapsed = '0;
        cover_mode   = MODE_OPENING;
      end
      ACT_CLOSE: begin
        secs_elapsed = '0;
        cover_mode   = MODE_CLOSING;
      end
      default: begin
        // status query, answers come from the mode before correction
        if (cover_mode == MODE_OPEN) begin
          if (tilt_closed) cover_mode = MODE_CLOSED;
          else q_open = 1'b1;
        end else if (cover_mode == MODE_CLOSED) begin
          if (!tilt_closed) cover_mode = MODE_OPEN;
          else q_closed = 1'b1;
        end
      end
    endcase
    r.cover_state        = cover_mode;
    r.motor_on           = (cover_mode == MODE_OPENING) || (cover_mode == MODE_CLOSING);
    r.motor_toward_close = (cover_mode == MODE_CLOSING);
    r.motor_power        = r.motor_on ? FULL_POWER : 8'd0;
    r.is_open            = q_open;
    r.is_closed          = q_closed;
    r.learned_seconds    = learned_valid ? learned_time : shadow_cfg.default_open;
    return r;
  endfunction

  // a result written out by hand
  function automatic result_t fixed_res(logic [1:0] mode, logic q_open, logic q_closed,
                                        logic [SecW-1:0] secs);
    result_t r;
    r.cover_state        = mode;
    r.motor_on           = (mode == MODE_OPENING) || (mode == MODE_CLOSING);
    r.motor_toward_close = (mode == MODE_CLOSING);
    r.motor_power        = r.motor_on ? FULL_POWER : 8'd0;
    r.is_open            = q_open;
    r.is_closed          = q_closed;
    r.learned_seconds    = secs;
    return r;
  endfunction

  function automatic void queue_request(logic [1:0] action, logic tilt_closed);
    cover_req_t item;
    item             = '0;
    item.action      = action;
    item.tilt_closed = tilt_closed;
    request_backlog.push_back(item);
    queued_total++;
  endfunction

  // request driver, bursts of random length with random gaps
  initial begin : request_source
    cover_req_t  cur;
    int unsigned burst_left;
    int unsigned gap_left;
    logic        offer;
    result_t     r;
    cur        = '0;
    burst_left = 0;
    gap_left   = 0;
    req_if.valid       <= 1'b0;
    req_if.action      <= ACT_TICK;
    req_if.tilt_closed <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (req_if.valid && req_if.ready) begin
        r = next_cover_result(cur.action, cur.tilt_closed);
        awaited_results.push_back(cur.fixed ? cur.want : r);
      end
      if (!req_if.valid || req_if.ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (rst_ni && request_backlog.size() != 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          cur   = request_backlog.pop_front();
          offer = 1'b1;
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        req_if.valid <= offer;
        if (offer) begin
          req_if.action      <= cur.action;
          req_if.tilt_closed <= cur.tilt_closed;
        end
      end
    end
  end

  // result receiver, stall pattern changes from window to window
  initial begin : result_sink
    int unsigned window_left;
    int unsigned hold_left;
    int unsigned sink_mode;
    logic [15:0] ready_pattern;
    window_left   = 0;
    hold_left     = 0;
    sink_mode     = 0;
    ready_pattern = '1;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        hold_left      = 90;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (window_left == 0) begin
          window_left   = 32;
          sink_mode     = $urandom_range(0, 2);
          ready_pattern = 16'($urandom_range(0, 16'hffff)) | 16'h0001;
        end
        window_left--;
        case (sink_mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= ready_pattern[4'(window_left % 16)];
          default: res_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // result checker
  initial begin : result_check
    result_t want;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request pending, expected none actual state %0d",
                   $time, res_if.cover_state);
        end else begin
          want = awaited_results.pop_front();
          check_field("cover_state", 32'(want.cover_state), 32'(res_if.cover_state));
          check_field("motor_on", 32'(want.motor_on), 32'(res_if.motor_on));
          check_field("motor_toward_close", 32'(want.motor_toward_close),
                      32'(res_if.motor_toward_close));
          check_field("motor_power", 32'(want.motor_power), 32'(res_if.motor_power));
          check_field("is_open", 32'(want.is_open), 32'(res_if.is_open));
          check_field("is_closed", 32'(want.is_closed), 32'(res_if.is_closed));
          check_field("learned_seconds", 32'(want.learned_seconds),
                      32'(res_if.learned_seconds));
        end
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("cover_motor_travel_controller_top verification failed");
    $finish;
  end

  // register write, valid stays up across back to back writes
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [SecW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_MIN_OPEN:     shadow_cfg.min_open = data;
      REG_MAX_OPEN:     shadow_cfg.max_open = data;
      REG_DEFAULT_OPEN: shadow_cfg.default_open = data;
      default: ;
    endcase
  endtask

  task automatic load_registers(input cfg_regs_t regs);
    write_register(REG_MIN_OPEN, regs.min_open);
    write_register(REG_MAX_OPEN, regs.max_open);
    write_register(REG_DEFAULT_OPEN, regs.default_open);
    cfg_if.valid <= 1'b0;
  endtask

  // wait until every request is out and every result is back
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (request_backlog.size() != 0 || req_if.valid || awaited_results.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // mostly command, ticks, query sequences, with some loose requests
  task automatic queue_random_phase(input int unsigned budget);
    int unsigned stop_at;
    int unsigned span;
    stop_at = queued_total + budget;
    while (queued_total < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        queue_request($urandom_range(0, 1) ? ACT_OPEN : ACT_CLOSE, 1'($urandom_range(0, 1)));
        span = (shadow_cfg.max_open > 20) ? 23 : shadow_cfg.max_open + 3;
        repeat ($urandom_range(0, span)) queue_request(ACT_TICK, $urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 2)) queue_request(ACT_QUERY, 1'($urandom_range(0, 1)));
      end else begin
        queue_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // main sequence
  initial begin : stimulus
    cover_req_t directed[18];
    cfg_regs_t  phases[7];
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_MIN_OPEN;
    cfg_if.data  <= '0;

    // directed checks at reset configuration
    directed[0]  = '{ACT_QUERY, 1'b0, 1'b1, fixed_res(MODE_OPEN, 1'b1, 1'b0, 16'd30)};
    directed[1]  = '{ACT_QUERY, 1'b1, 1'b1, fixed_res(MODE_CLOSED, 1'b0, 1'b0, 16'd30)};
    directed[2]  = '{ACT_QUERY, 1'b1, 1'b1, fixed_res(MODE_CLOSED, 1'b0, 1'b1, 16'd30)};
    directed[3]  = '{ACT_TICK, 1'b0, 1'b1, fixed_res(MODE_CLOSED, 1'b0, 1'b0, 16'd30)};
    directed[4]  = '{ACT_QUERY, 1'b0, 1'b1, fixed_res(MODE_OPEN, 1'b0, 1'b0, 16'd30)};
    directed[5]  = '{ACT_TICK, 1'b1, 1'b1, fixed_res(MODE_OPEN, 1'b0, 1'b0, 16'd30)};
    directed[6]  = '{ACT_OPEN, 1'b1, 1'b1, fixed_res(MODE_OPENING, 1'b0, 1'b0, 16'd30)};
    directed[7]  = '{ACT_QUERY, 1'b0, 1'b1, fixed_res(MODE_OPENING, 1'b0, 1'b0, 16'd30)};
    directed[8]  = '{ACT_TICK, 1'b1, 1'b0, '0};
    directed[9]  = '{ACT_TICK, 1'b0, 1'b0, '0};
    directed[10] = '{ACT_CLOSE, 1'b0, 1'b1, fixed_res(MODE_CLOSING, 1'b0, 1'b0, 16'd30)};
    directed[11] = '{ACT_QUERY, 1'b1, 1'b1, fixed_res(MODE_CLOSING, 1'b0, 1'b0, 16'd30)};
    directed[12] = '{ACT_TICK, 1'b1, 1'b0, '0};
    directed[13] = '{ACT_OPEN, 1'b0, 1'b1, fixed_res(MODE_OPENING, 1'b0, 1'b0, 16'd30)};
    directed[14] = '{ACT_TICK, 1'b0, 1'b0, '0};
    directed[15] = '{ACT_CLOSE, 1'b1, 1'b1, fixed_res(MODE_CLOSING, 1'b0, 1'b0, 16'd30)};
    directed[16] = '{ACT_TICK, 1'b0, 1'b0, '0};
    directed[17] = '{ACT_QUERY, 1'b0, 1'b1, fixed_res(MODE_CLOSING, 1'b0, 1'b0, 16'd30)};

    // register settings; the ones that cannot learn come first so the
    // default travel time stays visible
    phases[0] = '{min_open: 16'hffff, max_open: 16'd6, default_open: 16'hffff};
    phases[1] = '{min_open: 16'd0, max_open: 16'd0, default_open: 16'd1};
    phases[2] = '{min_open: 16'd0, max_open: 16'hffff, default_open: 16'd2};
    phases[3] = '{min_open: 16'd3, max_open: 16'd9, default_open: 16'd20};
    phases[4] = '{min_open: 16'd1, max_open: 16'd4, default_open: 16'd7};
    phases[5] = '{min_open: 16'd5, max_open: 16'd14, default_open: 16'd40};
    phases[6] = '{min_open: MIN_OPEN_RST, max_open: MAX_OPEN_RST,
                  default_open: DEFAULT_OPEN_RST};

    wait (rst_ni === 1'b1);
    foreach (directed[i]) begin
      request_backlog.push_back(directed[i]);
      queued_total++;
    end
    wait_quiet();

    foreach (phases[p]) begin
      load_registers(phases[p]);
      // long receiver hold-off while requests keep coming
      if (p == 0) long_stall_req = 1'b1;
      queue_random_phase(PhaseRequests);
      wait_quiet();
    end

    if (mismatch_count == 0 && awaited_results.size() == 0)
      $display("cover_motor_travel_controller_top verification clean");
    else
      $display("cover_motor_travel_controller_top verification failed");
    $finish;
  end

endmodule
